>>> sv/jfae_pkg.sv
// ============================================================================
// jfae_pkg: shared types and constants for the joystick frame decoder
// Sequencer states, register indexes, event record and fixed frame codes.
// ============================================================================
`default_nettype none

package jfae_pkg;

	// frame delimiters and window geometry
	localparam logic [7:0] FRAME_HEAD = 8'hFF;
	localparam logic [7:0] FRAME_TAIL = 8'hFE;
	localparam int unsigned WIN_DEPTH = 5;
	localparam logic [2:0] WIN_FULL = 3'd5;

	// scaling
	localparam logic [6:0] SCALE_MULT = 7'd126;
	localparam int unsigned NUM_W = 15;
	localparam logic [3:0] DIV_STEPS = 4'd15;
	localparam logic signed [7:0] AXIS_MAX = 8'sd127;
	localparam logic signed [7:0] AXIS_MIN = -8'sd128;

	// key thresholds
	localparam logic signed [7:0] KEY_POS_TH = 8'sd64;
	localparam logic signed [7:0] KEY_NEG_TH = -8'sd64;

	// calibration reset values
	localparam logic [7:0] X_LOW_RST = 8'd76;
	localparam logic [7:0] X_CENTER_RST = 8'd137;
	localparam logic [7:0] X_HIGH_RST = 8'd200;
	localparam logic [7:0] Y_LOW_RST = 8'd72;
	localparam logic [7:0] Y_CENTER_RST = 8'd135;
	localparam logic [7:0] Y_HIGH_RST = 8'd200;
	localparam logic [6:0] DEAD_BAND_RST = 7'd10;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_X_LOW    = 3'd0,
		REG_X_CENTER = 3'd1,
		REG_X_HIGH   = 3'd2,
		REG_Y_LOW    = 3'd3,
		REG_Y_CENTER = 3'd4,
		REG_Y_HIGH   = 3'd5,
		REG_DEAD     = 3'd6,
		REG_MODE     = 3'd7
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_POST,
		ST_OUT
	} state_t;

	// how the current axis value is formed
	typedef enum logic [1:0] {
		SC_DIVIDE,
		SC_CENTER,
		SC_NO_SPAN
	} scale_case_t;

	// event kinds, axes, keys (X positive is right, Y positive is down)
	localparam logic KIND_AXIS = 1'b0;
	localparam logic KIND_KEY = 1'b1;
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;
	localparam logic [1:0] KEY_X_POS = 2'd0;
	localparam logic [1:0] KEY_X_NEG = 2'd1;
	localparam logic [1:0] KEY_Y_POS = 2'd2;
	localparam logic [1:0] KEY_Y_NEG = 2'd3;
	localparam logic MODE_ANALOG = 1'b0;

	typedef struct packed {
		logic              kind;
		logic              axis;
		logic signed [7:0] value;
		logic [1:0]        key;
		logic              down;
	} event_t;

endpackage

`default_nettype wire

>>> sv/joystick_frame_to_axis_events.sv
// ============================================================================
// joystick_frame_to_axis_events
// Finds 0xFF ... 0xFE six-byte frames in a serial byte stream, scales the two
// axis readings against calibration and reports changes as stream events.
// ============================================================================
// One received byte is taken per transaction. A byte that does not close a
// frame is taken at once while the block is idle. A byte that closes a frame
// holds the input off through the computation and the reported events
// (zero to two), longer while the event side stalls: both axes go one after
// the other through a single 15-step restoring divider (1 setup, 15 divide
// steps, 1 finish per axis; the divide steps are skipped for an axis whose
// reading sits at center or whose span is zero). Calibration and mode must
// only be written while the block is idle.
`default_nettype none

module joystick_frame_to_axis_events (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [7:0]  cfg_data,
	// received bytes
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// events
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] axis_id, [8:1] axis_value,
	                                    // [10:9] key_id, [11] press, rest 0
	output logic        m_axis_tuser,   // [0] event_kind
	output logic        m_axis_tlast    // final_event
);
	import jfae_pkg::*;

	// configuration registers
	logic [7:0] x_low_q, x_center_q, x_high_q;
	logic [7:0] y_low_q, y_center_q, y_high_q;
	logic [6:0] dead_band_q;
	logic       report_mode_q;

	// frame search
	logic [7:0] win_q [WIN_DEPTH];
	logic [2:0] held_q;
	logic [7:0] raw_q [2];

	// sequencer and shared divider
	state_t            state_q, state_d;
	logic              axis_q;
	scale_case_t       case_q;
	logic              off_neg_q;
	logic              q_neg_q;
	logic [7:0]        den_q;
	logic [7:0]        rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [3:0]        step_q;
	logic signed [7:0] prev_q [2];

	// event buffer
	event_t     ev_q [2];
	logic [1:0] ev_cnt_q;
	logic       rd_idx_q;

	logic in_acc, out_acc, frame_hit;

	assign in_acc = s_axis_tvalid & s_axis_tready;
	assign out_acc = m_axis_tvalid & m_axis_tready;
	assign frame_hit = (held_q == WIN_FULL) && (win_q[0] == FRAME_HEAD)
		&& (s_axis_tdata == FRAME_TAIL);

	// operand selection for the axis being worked on
	logic [7:0]        cur_raw, cur_low, cur_ctr, cur_high;
	logic signed [8:0] off, span;
	logic [7:0]        off_mag, span_mag;
	logic [NUM_W-1:0]  num;

	always_comb begin
		cur_raw = raw_q[axis_q];
		cur_low = axis_q ? y_low_q : x_low_q;
		cur_ctr = axis_q ? y_center_q : x_center_q;
		cur_high = axis_q ? y_high_q : x_high_q;
		off = $signed({1'b0, cur_raw}) - $signed({1'b0, cur_ctr});
		if (off > 0) begin
			span = $signed({1'b0, cur_high}) - $signed({1'b0, cur_ctr});
		end else begin
			span = $signed({1'b0, cur_ctr}) - $signed({1'b0, cur_low});
		end
		off_mag = off[8] ? 8'(-off) : off[7:0];
		span_mag = span[8] ? 8'(-span) : span[7:0];
		num = NUM_W'(off_mag) * NUM_W'(SCALE_MULT);
	end

	// one restoring divider step
	logic [8:0] div_cand;
	logic       div_fit;

	assign div_cand = {rem_q, quo_q[NUM_W-1]};
	assign div_fit = div_cand >= {1'b0, den_q};

	// saturate and dead-zone the finished quotient
	logic signed [7:0] sat_val, new_val;
	logic [7:0]        new_mag;

	always_comb begin
		case (case_q)
			SC_CENTER: sat_val = '0;
			SC_NO_SPAN: sat_val = off_neg_q ? AXIS_MIN : AXIS_MAX;
			default: begin
				if (q_neg_q) begin
					sat_val = (quo_q > NUM_W'(128)) ? AXIS_MIN : 8'(-quo_q[7:0]);
				end else begin
					sat_val = (quo_q >= NUM_W'(127)) ? AXIS_MAX : quo_q[7:0];
				end
			end
		endcase
		new_mag = sat_val[7] ? 8'(-sat_val) : sat_val;
		new_val = (new_mag < {1'b0, dead_band_q}) ? '0 : sat_val;
	end

	// change detection and key crossing for the current axis
	logic signed [7:0] old_val;
	logic              ev_hit;
	event_t            ev_new;

	always_comb begin
		old_val = prev_q[axis_q];
		ev_new = '0;
		ev_new.axis = axis_q;
		ev_hit = 1'b0;
		if (new_val != old_val) begin
			if (report_mode_q == MODE_ANALOG) begin
				ev_hit = 1'b1;
				ev_new.kind = KIND_AXIS;
				ev_new.value = new_val;
			end else begin
				ev_new.kind = KIND_KEY;
				if (new_val >= KEY_POS_TH && old_val < KEY_POS_TH) begin
					ev_hit = 1'b1;
					ev_new.key = axis_q ? KEY_Y_POS : KEY_X_POS;
					ev_new.down = 1'b1;
				end else if (new_val < KEY_POS_TH && old_val >= KEY_POS_TH) begin
					ev_hit = 1'b1;
					ev_new.key = axis_q ? KEY_Y_POS : KEY_X_POS;
				end else if (new_val <= KEY_NEG_TH && old_val > KEY_NEG_TH) begin
					ev_hit = 1'b1;
					ev_new.key = axis_q ? KEY_Y_NEG : KEY_X_NEG;
					ev_new.down = 1'b1;
				end else if (new_val > KEY_NEG_TH && old_val <= KEY_NEG_TH) begin
					ev_hit = 1'b1;
					ev_new.key = axis_q ? KEY_Y_NEG : KEY_X_NEG;
				end
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_acc && frame_hit) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (off == 0 || span == 0) begin
					state_d = ST_POST;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == 4'd1) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (axis_q == AXIS_X) begin
					state_d = ST_LOAD;
				end else if (ev_cnt_q != 2'd0 || ev_hit) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (out_acc && m_axis_tlast) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// event output
	always_comb begin
		m_axis_tdata = {4'b0, ev_q[rd_idx_q].down, ev_q[rd_idx_q].key,
			ev_q[rd_idx_q].value, ev_q[rd_idx_q].axis};
		m_axis_tuser = ev_q[rd_idx_q].kind;
		m_axis_tlast = ({1'b0, rd_idx_q} == 2'(ev_cnt_q - 2'd1));
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q <= X_LOW_RST;
			x_center_q <= X_CENTER_RST;
			x_high_q <= X_HIGH_RST;
			y_low_q <= Y_LOW_RST;
			y_center_q <= Y_CENTER_RST;
			y_high_q <= Y_HIGH_RST;
			dead_band_q <= DEAD_BAND_RST;
			report_mode_q <= MODE_ANALOG;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_X_LOW: x_low_q <= cfg_data;
				REG_X_CENTER: x_center_q <= cfg_data;
				REG_X_HIGH: x_high_q <= cfg_data;
				REG_Y_LOW: y_low_q <= cfg_data;
				REG_Y_CENTER: y_center_q <= cfg_data;
				REG_Y_HIGH: y_high_q <= cfg_data;
				REG_DEAD: dead_band_q <= cfg_data[6:0];
				REG_MODE: report_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// byte window: fill, then slide; empties on a frame match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (in_acc) begin
			if (frame_hit) begin
				held_q <= '0;
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_q[i] <= '0;
				end
			end else if (held_q < WIN_FULL) begin
				win_q[held_q] <= s_axis_tdata;
				held_q <= held_q + 3'd1;
			end else begin
				for (int i = 0; i < WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WIN_DEPTH-1] <= s_axis_tdata;
			end
		end
	end

	// raw readings of a matched frame
	always_ff @(posedge clk) begin
		if (in_acc && frame_hit) begin
			raw_q[0] <= win_q[3];
			raw_q[1] <= win_q[4];
		end
	end

	// divider and scaling datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				off_neg_q <= off[8];
				q_neg_q <= off[8] ^ span[8];
				den_q <= span_mag;
				rem_q <= '0;
				quo_q <= num;
				step_q <= DIV_STEPS;
				if (off == 0) begin
					case_q <= SC_CENTER;
				end else if (span == 0) begin
					case_q <= SC_NO_SPAN;
				end else begin
					case_q <= SC_DIVIDE;
				end
			end
			ST_DIV: begin
				rem_q <= div_fit ? 8'(div_cand - {1'b0, den_q}) : div_cand[7:0];
				quo_q <= {quo_q[NUM_W-2:0], div_fit};
				step_q <= step_q - 4'd1;
			end
			default: ;
		endcase
	end

	// event buffer writes
	always_ff @(posedge clk) begin
		if (state_q == ST_POST && ev_hit) begin
			ev_q[ev_cnt_q[0]] <= ev_new;
		end
	end

	// axis selection, last values, event count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_X;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			ev_cnt_q <= '0;
			rd_idx_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					axis_q <= AXIS_X;
					ev_cnt_q <= '0;
					rd_idx_q <= 1'b0;
				end
				ST_POST: begin
					prev_q[axis_q] <= new_val;
					axis_q <= AXIS_Y;
					if (ev_hit) begin
						ev_cnt_q <= ev_cnt_q + 2'd1;
					end
				end
				ST_OUT: begin
					if (out_acc && !m_axis_tlast) begin
						rd_idx_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	// input is never taken while an event is on offer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("byte accepted while an event is pending");

	// remainder stays below the divisor throughout the division
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

	// an offered event always comes from a filled buffer slot
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ev_cnt_q != 2'd0 && {1'b0, rd_idx_q} < ev_cnt_q))
		else $error("event offered from an empty slot");

	// after the last event the block returns to taking bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> s_axis_tready)
		else $error("block did not return to idle after the last event");
`endif

endmodule

`default_nettype wire
